[rtl/core/oucs_pkg.sv]
// ----------------------------------------------------------------------------
// oucs_pkg
// Shared types and fixed constants of the noise current step stimulus.
// ----------------------------------------------------------------------------
package oucs_pkg;

    localparam int DECAY_W    = 16;
    localparam int CLIP_W     = 2;
    localparam int STEP_CNT_W = 10;
    localparam int STEP_IDX_W = 11;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        PHASE_CHANGE = 2'd0,
        PHASE_PAUSE  = 2'd1,
        PHASE_OU     = 2'd2,
        PHASE_DONE   = 2'd3
    } phase_t;

    typedef enum logic [CLIP_W-1:0] {
        CLIP_NONE  = 2'd0,
        CLIP_ABOVE = 2'd1,
        CLIP_BELOW = 2'd2,
        CLIP_OFF   = 2'd3
    } clip_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN        = 3'd0,
        REG_DECAY       = 3'd1,
        REG_CLIP        = 3'd2,
        REG_OU_TICKS    = 3'd3,
        REG_PAUSE_TICKS = 3'd4,
        REG_START       = 3'd5,
        REG_DELTA       = 3'd6,
        REG_STEP_COUNT  = 3'd7
    } cfg_reg_t;

endpackage

[rtl/core/oucs_ou_update.sv]
// ----------------------------------------------------------------------------
// oucs_ou_update
// One update of the Ornstein-Uhlenbeck value: decay toward the mean with
// rounding, add the noise sample, saturate and, per clip mode, clip to the mean.
// ----------------------------------------------------------------------------
module oucs_ou_update #(
    parameter int CURRENT_WIDTH = 24
) (
    input  logic signed [CURRENT_WIDTH-1:0]  ou_value,
    input  logic signed [CURRENT_WIDTH-1:0]  mean_current,
    input  logic [oucs_pkg::DECAY_W-1:0]     decay_factor,
    input  oucs_pkg::clip_t                  clip_mode,
    input  logic signed [CURRENT_WIDTH-1:0]  noise_sample,
    output logic signed [CURRENT_WIDTH-1:0]  ou_next
);
    import oucs_pkg::*;

    localparam int DIFF_W = CURRENT_WIDTH + 1;
    localparam int PROD_W = DIFF_W + DECAY_W + 1;
    localparam int TERM_W = PROD_W - DECAY_W;
    localparam int SUM_W  = CURRENT_WIDTH + 3;

    logic signed [DIFF_W-1:0]        diff;
    logic signed [DECAY_W:0]         decay_s;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        rounded;
    logic signed [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]         sum;
    logic signed [CURRENT_WIDTH-1:0] sat;

    assign diff    = DIFF_W'(ou_value) - DIFF_W'(mean_current);
    assign decay_s = $signed({1'b0, decay_factor});
    assign prod    = diff * decay_s;
    assign rounded = prod + PROD_W'(1 << (DECAY_W - 1));
    assign term    = rounded[PROD_W-1:DECAY_W];
    assign sum     = SUM_W'(mean_current) + SUM_W'(term) + SUM_W'(noise_sample);

    always_comb
    begin
        if (sum[SUM_W-1:CURRENT_WIDTH-1] == {(SUM_W-CURRENT_WIDTH+1){sum[SUM_W-1]}})
        begin
            sat = sum[CURRENT_WIDTH-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(CURRENT_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(CURRENT_WIDTH-1){1'b1}}};
        end

        ou_next = sat;
        case (clip_mode)
            CLIP_ABOVE:
            begin
                if (sat > mean_current)
                begin
                    ou_next = mean_current;
                end
            end
            CLIP_BELOW:
            begin
                if (sat < mean_current)
                begin
                    ou_next = mean_current;
                end
            end
            default:
            begin
                ou_next = sat;
            end
        endcase
    end

endmodule

[rtl/core/ou_noise_current_step_stimulus.sv]
// ----------------------------------------------------------------------------
// ou_noise_current_step_stimulus
// Current-step protocol with Ornstein-Uhlenbeck noise and an added oscillation.
//
//   Channel  Signals                         Moves
//   in       in_valid, in_ready              one tick: noise and oscillation
//   out      out_valid, out_ready            one result per tick
//   cfg      cfg_valid, cfg_ready            register index and data
//
// Each tick passes through the input register and then the result
// register; a new transfer is taken every cycle while results are drained.
// The OU update loop (one multiply, rounding add, saturation) sets the rate.
// Reset restores register defaults, step 1, tick 0 and a zero OU value.
// A stalled result holds; the input register still refills behind it once.
// Every configuration write restarts the protocol; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ou_noise_current_step_stimulus #(
    parameter int CURRENT_WIDTH = 24,
    parameter int TICK_WIDTH    = 32,
    localparam int CFG_W = (CURRENT_WIDTH > TICK_WIDTH) ? CURRENT_WIDTH : TICK_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [CURRENT_WIDTH-1:0]    noise_sample,
    input  logic signed [CURRENT_WIDTH-1:0]    oscillation_sample,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [CURRENT_WIDTH-1:0]    drive_current,
    output logic signed [CURRENT_WIDTH-1:0]    ou_level,
    output logic signed [CURRENT_WIDTH-1:0]    step_level,
    output logic [1:0]                         phase_code,
    output logic [oucs_pkg::STEP_IDX_W-1:0]    step_index,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [oucs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data
);
    import oucs_pkg::*;

    localparam int CW     = CURRENT_WIDTH;
    localparam int TW     = TICK_WIDTH;
    localparam int ACC_W  = CW + STEP_IDX_W;
    localparam int DRV_W  = CW + 2;

    localparam logic signed [CW-1:0] RST_MEAN   = CW'(0);
    localparam logic [DECAY_W-1:0]   RST_DECAY  = DECAY_W'(65535);
    localparam logic [TW-1:0]        RST_OU     = TW'(100000);
    localparam logic [TW-1:0]        RST_PAUSE  = TW'(50000);
    localparam logic signed [CW-1:0] RST_START  = CW'(-12800);
    localparam logic signed [CW-1:0] RST_DELTA  = CW'(2560);
    localparam logic [STEP_CNT_W-1:0] RST_COUNT = STEP_CNT_W'(26);

    logic signed [CW-1:0]      mean_current_reg;
    logic [DECAY_W-1:0]        decay_factor_reg;
    clip_t                     clip_mode_reg;
    logic [TW-1:0]             ou_ticks_reg;
    logic [TW-1:0]             pause_ticks_reg;
    logic signed [CW-1:0]      start_current_reg;
    logic signed [CW-1:0]      step_delta_reg;
    logic [STEP_CNT_W-1:0]     step_count_reg;

    logic signed [CW-1:0]      ou_value_reg;
    logic signed [CW-1:0]      ou_value_next;
    logic [TW:0]               tick_reg;
    logic [TW:0]               tick_next;
    logic [STEP_IDX_W-1:0]     step_reg;
    logic [STEP_IDX_W-1:0]     step_next;
    logic signed [ACC_W-1:0]   level_acc_reg;
    logic signed [ACC_W-1:0]   level_acc_next;

    logic                      s1_valid_reg;
    logic signed [CW-1:0]      noise_reg;
    logic signed [CW-1:0]      osc_reg;

    logic                      out_valid_reg;
    logic signed [CW-1:0]      drive_reg;
    logic signed [CW-1:0]      drive_next;
    logic signed [CW-1:0]      ou_level_reg;
    logic signed [CW-1:0]      level_reg;
    logic signed [CW-1:0]      level_next;
    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [STEP_IDX_W-1:0]     step_index_reg;

    logic                      cfg_write;
    logic                      s2_load;
    logic                      finished;
    logic                      in_pause;
    logic                      in_window;
    logic [TW:0]               window_end;
    logic signed [CW-1:0]      ou_update;
    logic signed [CW-1:0]      level_sat;
    logic signed [DRV_W-1:0]   drive_sum;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_current_reg  <= RST_MEAN;
            decay_factor_reg  <= RST_DECAY;
            clip_mode_reg     <= CLIP_ABOVE;
            ou_ticks_reg      <= RST_OU;
            pause_ticks_reg   <= RST_PAUSE;
            start_current_reg <= RST_START;
            step_delta_reg    <= RST_DELTA;
            step_count_reg    <= RST_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MEAN:        mean_current_reg  <= cfg_data[CW-1:0];
                REG_DECAY:       decay_factor_reg  <= cfg_data[DECAY_W-1:0];
                REG_CLIP:        clip_mode_reg     <= clip_t'(cfg_data[CLIP_W-1:0]);
                REG_OU_TICKS:    ou_ticks_reg      <= cfg_data[TW-1:0];
                REG_PAUSE_TICKS: pause_ticks_reg   <= cfg_data[TW-1:0];
                REG_START:       start_current_reg <= cfg_data[CW-1:0];
                REG_DELTA:       step_delta_reg    <= cfg_data[CW-1:0];
                REG_STEP_COUNT:  step_count_reg    <= cfg_data[STEP_CNT_W-1:0];
                default:         step_count_reg    <= step_count_reg;
            endcase
        end
    end

    oucs_ou_update #(
        .CURRENT_WIDTH (CW)
    ) u_ou_update (
        .ou_value     (ou_value_reg),
        .mean_current (mean_current_reg),
        .decay_factor (decay_factor_reg),
        .clip_mode    (clip_mode_reg),
        .noise_sample (noise_reg),
        .ou_next      (ou_update)
    );

    assign finished   = step_reg > {1'b0, step_count_reg};
    assign window_end = {1'b0, pause_ticks_reg} + {1'b0, ou_ticks_reg};
    assign in_pause   = tick_reg < {1'b0, pause_ticks_reg};
    assign in_window  = tick_reg < window_end;

    always_comb
    begin
        if (level_acc_reg[ACC_W-1:CW-1] == {(ACC_W-CW+1){level_acc_reg[ACC_W-1]}})
        begin
            level_sat = level_acc_reg[CW-1:0];
        end
        else if (level_acc_reg[ACC_W-1])
        begin
            level_sat = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            level_sat = {1'b0, {(CW-1){1'b1}}};
        end

        drive_sum = DRV_W'(ou_update) + DRV_W'(osc_reg) + DRV_W'(level_sat);
    end

    always_comb
    begin
        ou_value_next  = ou_value_reg;
        tick_next      = tick_reg;
        step_next      = step_reg;
        level_acc_next = level_acc_reg;
        phase_next     = PHASE_DONE;
        level_next     = '0;
        drive_next     = '0;

        if (finished)
        begin
            phase_next = PHASE_DONE;
        end
        else if (in_pause)
        begin
            phase_next    = PHASE_PAUSE;
            ou_value_next = '0;
            tick_next     = tick_reg + 1'b1;
        end
        else if (in_window)
        begin
            phase_next    = PHASE_OU;
            ou_value_next = ou_update;
            tick_next     = tick_reg + 1'b1;
            level_next    = level_sat;
            if (drive_sum[DRV_W-1:CW-1] == {3{drive_sum[DRV_W-1]}})
            begin
                drive_next = drive_sum[CW-1:0];
            end
            else if (drive_sum[DRV_W-1])
            begin
                drive_next = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                drive_next = {1'b0, {(CW-1){1'b1}}};
            end
        end
        else
        begin
            phase_next     = PHASE_CHANGE;
            ou_value_next  = '0;
            tick_next      = '0;
            step_next      = step_reg + 1'b1;
            level_acc_next = level_acc_reg + ACC_W'(step_delta_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ou_value_reg  <= '0;
            tick_reg      <= '0;
            step_reg      <= STEP_IDX_W'(1);
            level_acc_reg <= ACC_W'(RST_START);
        end
        else if (cfg_write)
        begin
            tick_reg <= '0;
            step_reg <= STEP_IDX_W'(1);
            if (cfg_reg_t'(cfg_index) == REG_START)
            begin
                level_acc_reg <= ACC_W'($signed(cfg_data[CW-1:0]));
            end
            else
            begin
                level_acc_reg <= ACC_W'(start_current_reg);
            end
        end
        else if (s2_load)
        begin
            ou_value_reg  <= ou_value_next;
            tick_reg      <= tick_next;
            step_reg      <= step_next;
            level_acc_reg <= level_acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            noise_reg <= noise_sample;
            osc_reg   <= oscillation_sample;
        end
        if (s2_load)
        begin
            drive_reg      <= drive_next;
            ou_level_reg   <= ou_value_next;
            level_reg      <= level_next;
            phase_reg      <= phase_next;
            step_index_reg <= step_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_current = drive_reg;
    assign ou_level      = ou_level_reg;
    assign step_level    = level_reg;
    assign phase_code    = phase_reg;
    assign step_index    = step_index_reg;

    a_idle_output_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while the result register is empty");

    a_zero_outside_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (phase_reg != PHASE_OU) |-> (drive_reg == '0) && (level_reg == '0))
        else $error("nonzero drive or step level outside the OU window");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= {1'b0, step_count_reg} + STEP_IDX_W'(1) || step_reg == STEP_IDX_W'(1))
        else $error("step number ran past the last step");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (step_reg == STEP_IDX_W'(1)) && (tick_reg == '0))
        else $error("configuration transfer did not restart the protocol");

    a_change_zeroes_ou: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((phase_reg == PHASE_CHANGE) || (phase_reg == PHASE_PAUSE))
        |-> ou_level_reg == '0)
        else $error("OU value not cleared in pause or step change");

endmodule
